// ----- design/dfk_pkg.sv -----
// Shared types, link constants and helper functions for the six-joint forward kinematics pipeline.
package dfk_pkg;

    // Number of joints in the chain.
    localparam int NUM_JOINTS = 6;

    // Default output fraction bits.
    localparam int FRAC_BITS_DEF = 16;

    // Number of CORDIC iterations.
    localparam int CORDIC_STEPS = 14;

    // Width of a Q30 rotation or trig value (range +-2.0).
    localparam int RW = 32;

    // Width of a Q30 position value (range +-8.0 m).
    localparam int PW = 34;

    // Width of the CORDIC residual angle.
    localparam int ZW = 18;

    // Width of a wide Q60 accumulator.
    localparam int AW = 68;

    // CORDIC start value: the inverse gain in Q30.
    localparam logic signed [RW-1:0] CORDIC_GAIN = 32'sd652032874;

    // One in Q30.
    localparam logic signed [RW-1:0] Q30_ONE = 32'sd1073741824;

    typedef logic signed [RW-1:0] q30_t;
    typedef logic signed [PW-1:0] pos_t;
    typedef q30_t rot_mat_t [3][3];
    typedef pos_t pos_vec_t [3];

    // Arc tangent of 2^-i in binary-angle units.
    function automatic int cordic_atan(input int i);
        int v;
        begin
            case (i)
                0:       v = 8192;
                1:       v = 4836;
                2:       v = 2555;
                3:       v = 1297;
                4:       v = 651;
                5:       v = 326;
                6:       v = 163;
                7:       v = 81;
                8:       v = 41;
                9:       v = 20;
                10:      v = 10;
                11:      v = 5;
                12:      v = 3;
                13:      v = 1;
                default: v = 0;
            endcase
            return v;
        end
    endfunction

    // Link offset d in units of 0.1 mm.
    function automatic int link_d(input int j);
        int v;
        begin
            case (j)
                0:       v = 2363;
                3:       v = 2010;
                4:       v = 1593;
                5:       v = 1543;
                default: v = 0;
            endcase
            return v;
        end
    endfunction

    // Link length r in units of 0.1 mm.
    function automatic int link_r(input int j);
        int v;
        begin
            case (j)
                1:       v = -8620;
                2:       v = -7287;
                default: v = 0;
            endcase
            return v;
        end
    endfunction

    // Sign of the sine of the link twist; zero means no twist.
    function automatic int link_tw(input int j);
        int v;
        begin
            case (j)
                0:       v = 1;
                3:       v = 1;
                4:       v = -1;
                default: v = 0;
            endcase
            return v;
        end
    endfunction

    // Converts 0.1 mm units to Q30 metres, halves rounded away from zero.
    function automatic longint q30_of_tenth_mm(input int n);
        longint mag;
        longint q;
        begin
            mag = (n < 0) ? -longint'(n) : longint'(n);
            q = (mag * 64'sd1073741824 + 64'sd5000) / 10000;
            return (n < 0) ? -q : q;
        end
    endfunction

    // Rounds a Q60 sum to Q30 with halves rounded up.
    function automatic logic signed [AW-31:0] round_q60(input logic signed [AW-1:0] v);
        logic signed [AW-1:0] t;
        begin
            t = (v + (AW'(1) <<< 29)) >>> 30;
            return t[AW-31:0];
        end
    endfunction

endpackage

// ----- design/dh_forward_kinematics_6dof.sv -----
// Top level of the six-joint forward kinematics pipeline.
// Computes tool position and rotation from six binary joint angles. The block takes one
// request per clock while the output is not stalled and returns one result per request,
// passing through the CORDIC stages for all six joints in parallel, the stages of each of
// the six links in turn and one output rounding stage. A stall on the output freezes the
// whole pipeline, so in_stall is high exactly when a result waits and out_stall is high.
// Rotation entries saturate at +-1.0 (or the 18-bit range if smaller), positions at 19 bits.
module dh_forward_kinematics_6dof #(
    parameter int FRAC_BITS = dfk_pkg::FRAC_BITS_DEF
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_stall,
    input  logic signed [15:0]  joint_angle_0,
    input  logic signed [15:0]  joint_angle_1,
    input  logic signed [15:0]  joint_angle_2,
    input  logic signed [15:0]  joint_angle_3,
    input  logic signed [15:0]  joint_angle_4,
    input  logic signed [15:0]  joint_angle_5,
    output logic                out_valid,
    input  logic                out_stall,
    output logic signed [18:0]  pos_x,
    output logic signed [18:0]  pos_y,
    output logic signed [18:0]  pos_z,
    output logic signed [17:0]  rot_00,
    output logic signed [17:0]  rot_01,
    output logic signed [17:0]  rot_02,
    output logic signed [17:0]  rot_10,
    output logic signed [17:0]  rot_11,
    output logic signed [17:0]  rot_12,
    output logic signed [17:0]  rot_20,
    output logic signed [17:0]  rot_21,
    output logic signed [17:0]  rot_22
);

    localparam int NJ = dfk_pkg::NUM_JOINTS;
    localparam int RW = dfk_pkg::RW;
    localparam int PW = dfk_pkg::PW;
    localparam int SH = 30 - FRAC_BITS;
    localparam longint RLIM_RAW = longint'(1) << FRAC_BITS;
    localparam longint RLIM = (RLIM_RAW > 131071) ? 131071 : RLIM_RAW;
    localparam logic signed [RW-1:0] ROT_HI = RW'(RLIM);
    localparam logic signed [RW-1:0] ROT_LO = -RW'(RLIM);
    localparam logic signed [PW-1:0] POS_HI = PW'(262143);
    localparam logic signed [PW-1:0] POS_LO = -PW'(262144);

    logic                   en;
    logic signed [15:0]     ang [NJ];
    logic                   cord_v [NJ];
    dfk_pkg::q30_t          cord_c [NJ];
    dfk_pkg::q30_t          cord_s [NJ];
    dfk_pkg::q30_t          link_c [NJ];
    dfk_pkg::q30_t          link_s [NJ];
    logic                   chain_v [NJ+1];
    dfk_pkg::rot_mat_t      chain_r [NJ+1];
    dfk_pkg::pos_vec_t      chain_p [NJ+1];
    logic                   ov_reg;
    logic signed [18:0]     pos_reg [3];
    logic signed [17:0]     rot_reg [3][3];
    logic signed [18:0]     pos_next [3];
    logic signed [17:0]     rot_next [3][3];

    // The pipeline moves whenever the output register is free or being taken.
    assign en       = !(ov_reg && out_stall);
    assign in_stall = !en;

    assign ang[0] = joint_angle_0;
    assign ang[1] = joint_angle_1;
    assign ang[2] = joint_angle_2;
    assign ang[3] = joint_angle_3;
    assign ang[4] = joint_angle_4;
    assign ang[5] = joint_angle_5;

    // Sine and cosine of all joints, with later joints delayed to meet their link stage.
    for (genvar j = 0; j < NJ; j++)
    begin : g_joint
        dfk_cordic u_cordic (
            .clk       (clk),
            .rst_n     (rst_n),
            .en        (en),
            .in_valid  (in_valid),
            .angle     (ang[j]),
            .out_valid (cord_v[j]),
            .cos_q     (cord_c[j]),
            .sin_q     (cord_s[j])
        );

        if (j == 0)
        begin : g_direct
            assign link_c[j] = cord_c[j];
            assign link_s[j] = cord_s[j];
        end
        else
        begin : g_delay
            dfk_pkg::q30_t cd_reg [3*j];
            dfk_pkg::q30_t sd_reg [3*j];

            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    cd_reg[0] <= cord_c[j];
                    sd_reg[0] <= cord_s[j];
                    for (int k = 1; k < 3*j; k++)
                    begin
                        cd_reg[k] <= cd_reg[k-1];
                        sd_reg[k] <= sd_reg[k-1];
                    end
                end
            end

            assign link_c[j] = cd_reg[3*j-1];
            assign link_s[j] = sd_reg[3*j-1];
        end
    end

    // The chain starts from the identity pose.
    assign chain_v[0] = cord_v[0];
    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            for (int k = 0; k < 3; k++)
            begin
                chain_r[0][i][k] = (i == k) ? dfk_pkg::Q30_ONE : '0;
            end
            chain_p[0][i] = '0;
        end
    end

    // Six link stages in a row.
    for (genvar j = 0; j < NJ; j++)
    begin : g_link
        dfk_link #(
            .LINK (j)
        ) u_link (
            .clk       (clk),
            .rst_n     (rst_n),
            .en        (en),
            .in_valid  (chain_v[j]),
            .c_in      (link_c[j]),
            .s_in      (link_s[j]),
            .rot_in    (chain_r[j]),
            .pos_in    (chain_p[j]),
            .out_valid (chain_v[j+1]),
            .rot_out   (chain_r[j+1]),
            .pos_out   (chain_p[j+1])
        );
    end

    // Round to the output fraction and saturate.
    always_comb
    begin
        logic signed [PW-1:0] pr;
        logic signed [RW-1:0] rr;
        for (int i = 0; i < 3; i++)
        begin
            pr = (chain_p[NJ][i] + (PW'(1) <<< (SH - 1))) >>> SH;
            if (pr < POS_LO)
            begin
                pr = POS_LO;
            end
            else if (pr > POS_HI)
            begin
                pr = POS_HI;
            end
            pos_next[i] = pr[18:0];
            for (int k = 0; k < 3; k++)
            begin
                rr = (chain_r[NJ][i][k] + (RW'(1) <<< (SH - 1))) >>> SH;
                if (rr < ROT_LO)
                begin
                    rr = ROT_LO;
                end
                else if (rr > ROT_HI)
                begin
                    rr = ROT_HI;
                end
                rot_next[i][k] = rr[17:0];
            end
        end
    end

    // Output register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ov_reg <= 1'b0;
        end
        else if (en)
        begin
            ov_reg <= chain_v[NJ];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            pos_reg <= pos_next;
            rot_reg <= rot_next;
        end
    end

    assign out_valid = ov_reg;
    assign pos_x  = pos_reg[0];
    assign pos_y  = pos_reg[1];
    assign pos_z  = pos_reg[2];
    assign rot_00 = rot_reg[0][0];
    assign rot_01 = rot_reg[0][1];
    assign rot_02 = rot_reg[0][2];
    assign rot_10 = rot_reg[1][0];
    assign rot_11 = rot_reg[1][1];
    assign rot_12 = rot_reg[1][2];
    assign rot_20 = rot_reg[2][0];
    assign rot_21 = rot_reg[2][1];
    assign rot_22 = rot_reg[2][2];

endmodule

// ----- design/dfk_cordic.sv -----
// Pipelined rotation-mode CORDIC that turns one binary angle into Q30 cosine and sine.
module dfk_cordic (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    en,
    input  logic                    in_valid,
    input  logic signed [15:0]      angle,
    output logic                    out_valid,
    output dfk_pkg::q30_t           cos_q,
    output dfk_pkg::q30_t           sin_q
);

    localparam int N  = dfk_pkg::CORDIC_STEPS;
    localparam int RW = dfk_pkg::RW;
    localparam int ZW = dfk_pkg::ZW;

    logic signed [RW-1:0] x_reg [N+1];
    logic signed [RW-1:0] y_reg [N+1];
    logic signed [ZW-1:0] z_reg [N+1];
    logic                 neg_reg [N+1];
    logic                 v_reg [N+1];
    logic signed [RW-1:0] cos_reg;
    logic signed [RW-1:0] sin_reg;
    logic                 vo_reg;
    logic signed [ZW-1:0] fold_next;
    logic                 neg_next;

    // Fold the angle into the right half plane.
    always_comb
    begin
        if (angle > 16'sd16384)
        begin
            fold_next = ZW'(angle) - ZW'(32768);
            neg_next  = 1'b1;
        end
        else if (angle < -16'sd16384)
        begin
            fold_next = ZW'(angle) + ZW'(32768);
            neg_next  = 1'b1;
        end
        else
        begin
            fold_next = ZW'(angle);
            neg_next  = 1'b0;
        end
    end

    // Fold stage payload.
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            x_reg[0]   <= dfk_pkg::CORDIC_GAIN;
            y_reg[0]   <= '0;
            z_reg[0]   <= fold_next;
            neg_reg[0] <= neg_next;
        end
    end

    // Valid bits of every stage.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k <= N; k++)
            begin
                v_reg[k] <= 1'b0;
            end
            vo_reg <= 1'b0;
        end
        else if (en)
        begin
            v_reg[0] <= in_valid;
            for (int k = 1; k <= N; k++)
            begin
                v_reg[k] <= v_reg[k-1];
            end
            vo_reg <= v_reg[N];
        end
    end

    // One micro-rotation per stage.
    for (genvar i = 0; i < N; i++)
    begin : g_iter
        localparam logic signed [ZW-1:0] ATAN = ZW'(dfk_pkg::cordic_atan(i));
        logic signed [RW-1:0] dx;
        logic signed [RW-1:0] dy;

        assign dx = y_reg[i] >>> i;
        assign dy = x_reg[i] >>> i;

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                if (z_reg[i] >= 0)
                begin
                    x_reg[i+1] <= x_reg[i] - dx;
                    y_reg[i+1] <= y_reg[i] + dy;
                    z_reg[i+1] <= z_reg[i] - ATAN;
                end
                else
                begin
                    x_reg[i+1] <= x_reg[i] + dx;
                    y_reg[i+1] <= y_reg[i] - dy;
                    z_reg[i+1] <= z_reg[i] + ATAN;
                end
                neg_reg[i+1] <= neg_reg[i];
            end
        end
    end

    // Undo the fold by negating both results.
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            cos_reg <= neg_reg[N] ? -x_reg[N] : x_reg[N];
            sin_reg <= neg_reg[N] ? -y_reg[N] : y_reg[N];
        end
    end

    assign out_valid = vo_reg;
    assign cos_q     = cos_reg;
    assign sin_q     = sin_reg;

endmodule

// ----- design/dfk_link.sv -----
// Three-stage pipeline that applies one Denavit-Hartenberg link transform to the running pose.
module dfk_link #(
    parameter int LINK = 0
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                en,
    input  logic                in_valid,
    input  dfk_pkg::q30_t       c_in,
    input  dfk_pkg::q30_t       s_in,
    input  dfk_pkg::rot_mat_t   rot_in,
    input  dfk_pkg::pos_vec_t   pos_in,
    output logic                out_valid,
    output dfk_pkg::rot_mat_t   rot_out,
    output dfk_pkg::pos_vec_t   pos_out
);

    localparam int RW = dfk_pkg::RW;
    localparam int PW = dfk_pkg::PW;
    localparam int AW = dfk_pkg::AW;
    localparam int TW = dfk_pkg::link_tw(LINK);
    localparam logic signed [RW-1:0] RQ = RW'(dfk_pkg::q30_of_tenth_mm(dfk_pkg::link_r(LINK)));
    localparam logic signed [PW-1:0] DQ = PW'(dfk_pkg::q30_of_tenth_mm(dfk_pkg::link_d(LINK)));

    // Stage one: link position terms.
    logic                   v1_reg;
    dfk_pkg::q30_t          c1_reg;
    dfk_pkg::q30_t          s1_reg;
    dfk_pkg::rot_mat_t      r1_reg;
    dfk_pkg::pos_vec_t      p1_reg;
    logic signed [PW-1:0]   a0_reg;
    logic signed [PW-1:0]   a1_reg;
    logic signed [PW-1:0]   a0_next;
    logic signed [PW-1:0]   a1_next;
    logic signed [2*RW-1:0] rc_prod;
    logic signed [2*RW-1:0] rs_prod;

    // Stage two: products.
    logic                   v2_reg;
    logic signed [2*RW-1:0] pc_reg [3][4];
    logic signed [RW+PW-1:0] pp_reg [3][3];
    dfk_pkg::q30_t          r2_reg [3];
    dfk_pkg::pos_vec_t      p2_reg;

    // Stage three: sums.
    logic                   v3_reg;
    dfk_pkg::rot_mat_t      r3_reg;
    dfk_pkg::pos_vec_t      p3_reg;
    dfk_pkg::rot_mat_t      r3_next;
    dfk_pkg::pos_vec_t      p3_next;

    // Link length times cosine and sine.
    assign rc_prod = RQ * c_in;
    assign rs_prod = RQ * s_in;
    assign a0_next = PW'(dfk_pkg::round_q60(AW'(rc_prod)));
    assign a1_next = PW'(dfk_pkg::round_q60(AW'(rs_prod)));

    // Valid bits.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else if (en)
        begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
        end
    end

    // Stage one and two payload.
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            c1_reg <= c_in;
            s1_reg <= s_in;
            r1_reg <= rot_in;
            p1_reg <= pos_in;
            a0_reg <= a0_next;
            a1_reg <= a1_next;
            for (int i = 0; i < 3; i++)
            begin
                pc_reg[i][0] <= r1_reg[i][0] * c1_reg;
                pc_reg[i][1] <= r1_reg[i][0] * s1_reg;
                pc_reg[i][2] <= r1_reg[i][1] * c1_reg;
                pc_reg[i][3] <= r1_reg[i][1] * s1_reg;
                pp_reg[i][0] <= r1_reg[i][0] * a0_reg;
                pp_reg[i][1] <= r1_reg[i][1] * a1_reg;
                pp_reg[i][2] <= r1_reg[i][2] * DQ;
                r2_reg[i]    <= r1_reg[i][2];
            end
            p2_reg <= p1_reg;
        end
    end

    // Row sums, rounding and the exact twist selections.
    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            r3_next[i][0] = RW'(dfk_pkg::round_q60(AW'(pc_reg[i][0]) + AW'(pc_reg[i][3])));
            if (TW == 0)
            begin
                r3_next[i][1] = RW'(dfk_pkg::round_q60(AW'(pc_reg[i][2]) - AW'(pc_reg[i][1])));
                r3_next[i][2] = r2_reg[i];
            end
            else if (TW > 0)
            begin
                r3_next[i][1] = r2_reg[i];
                r3_next[i][2] = RW'(dfk_pkg::round_q60(AW'(pc_reg[i][1]) - AW'(pc_reg[i][2])));
            end
            else
            begin
                r3_next[i][1] = -r2_reg[i];
                r3_next[i][2] = RW'(dfk_pkg::round_q60(AW'(pc_reg[i][2]) - AW'(pc_reg[i][1])));
            end
            p3_next[i] = PW'(dfk_pkg::round_q60(AW'(pp_reg[i][0]) + AW'(pp_reg[i][1])
                                                + AW'(pp_reg[i][2]))) + p2_reg[i];
        end
    end

    // Stage three payload.
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            r3_reg <= r3_next;
            p3_reg <= p3_next;
        end
    end

    assign out_valid = v3_reg;
    assign rot_out   = r3_reg;
    assign pos_out   = p3_reg;

endmodule

// ----- design/dfk_checker.sv -----
// Port-level checker for the forward kinematics pipeline and its bind statement.
module dfk_checker #(
    parameter int FRAC_BITS = dfk_pkg::FRAC_BITS_DEF
) (
    input logic               clk,
    input logic               rst_n,
    input logic               in_stall,
    input logic               out_valid,
    input logic               out_stall,
    input logic signed [17:0] rot_00,
    input logic signed [17:0] rot_22
);

    localparam longint LIM_RAW = longint'(1) << FRAC_BITS;
    localparam logic signed [17:0] LIM = 18'((LIM_RAW > 131071) ? 131071 : LIM_RAW);

    // The input side stalls exactly when a result waits on a stalled output.
    a_stall_link: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall == (out_valid && out_stall))
        else $error("in_stall does not follow the output stall");

    // A stalled result stays valid, and rot_00 and rot_22 stay unchanged.
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(rot_00) && $stable(rot_22))
        else $error("stalled result changed");

    // Rotation entries rot_00 and rot_22 stay within the saturation limit.
    a_rot00: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (rot_00 <= LIM) && (rot_00 >= -LIM))
        else $error("rot_00 beyond limit");

    a_rot22: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (rot_22 <= LIM) && (rot_22 >= -LIM))
        else $error("rot_22 beyond limit");

endmodule

bind dh_forward_kinematics_6dof dfk_checker #(
    .FRAC_BITS (FRAC_BITS)
) u_dfk_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .rot_00    (rot_00),
    .rot_22    (rot_22)
);

// ----- tb/tb_top.sv -----
// Self-checking testbench for the six-joint forward kinematics pipeline.
module tb_top;

    localparam int FRAC = 16;
    localparam int LATENCY = 35;

    typedef struct packed {
        logic [18:0] px, py, pz;
        logic [17:0] r00, r01, r02, r10, r11, r12, r20, r21, r22;
    } pose_t;

    logic clk;
    logic rst_n;
    logic in_valid;
    logic in_stall;
    logic signed [15:0] ang [6];
    logic out_valid;
    logic out_stall;
    logic signed [18:0] pos_x, pos_y, pos_z;
    logic signed [17:0] rot_00, rot_01, rot_02, rot_10, rot_11, rot_12;
    logic signed [17:0] rot_20, rot_21, rot_22;

    pose_t expected_poses[$];
    int mismatches;
    int burst_left;

    dh_forward_kinematics_6dof dut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_stall(in_stall),
        .joint_angle_0(ang[0]), .joint_angle_1(ang[1]), .joint_angle_2(ang[2]),
        .joint_angle_3(ang[3]), .joint_angle_4(ang[4]), .joint_angle_5(ang[5]),
        .out_valid(out_valid), .out_stall(out_stall),
        .pos_x(pos_x), .pos_y(pos_y), .pos_z(pos_z),
        .rot_00(rot_00), .rot_01(rot_01), .rot_02(rot_02),
        .rot_10(rot_10), .rot_11(rot_11), .rot_12(rot_12),
        .rot_20(rot_20), .rot_21(rot_21), .rot_22(rot_22)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Division by a power of two with halves rounded up; >>> on longint floors.
    function automatic longint round_shift(input longint v, input int s);
        return (v + (longint'(1) <<< (s - 1))) >>> s;
    endfunction

    // Q0.1mm link constant to Q30, halves away from zero.
    function automatic longint tenth_mm_q30(input int n);
        longint mag;
        longint q;
        mag = (n < 0) ? -longint'(n) : longint'(n);
        q = (mag * 64'sd1073741824 + 64'sd5000) / 10000;
        return (n < 0) ? -q : q;
    endfunction

    // CORDIC sine and cosine of a binary angle, both Q30.
    task automatic cordic_sincos(input logic signed [15:0] a_in, output longint c,
                                 output longint s);
        int a;
        bit flip;
        longint x, y, z, dx, dy;
        int atans [14];
        atans = '{8192, 4836, 2555, 1297, 651, 326, 163, 81, 41, 20, 10, 5, 3, 1};
        a = a_in;
        flip = 1'b0;
        if (a > 16384)
        begin
            a -= 32768;
            flip = 1'b1;
        end
        else if (a < -16384)
        begin
            a += 32768;
            flip = 1'b1;
        end
        x = 652032874;
        y = 0;
        z = a;
        for (int i = 0; i < 14; i++)
        begin
            dx = y >>> i;
            dy = x >>> i;
            if (z >= 0)
            begin
                x -= dx; y += dy; z -= atans[i];
            end
            else
            begin
                x += dx; y -= dy; z += atans[i];
            end
        end
        c = flip ? -x : x;
        s = flip ? -y : y;
    endtask

    function automatic longint clamp(input longint v, input longint lo, input longint hi);
        return (v < lo) ? lo : ((v > hi) ? hi : v);
    endfunction

    // Chains the six link transforms and quantizes the tool pose.
    task automatic predict_pose(input logic signed [15:0] q [6], output pose_t pose);
        longint rm [3][3], nr [3][3], lk [3][3], p [3], np [3], lp [3];
        longint c, s, acc, rlim;
        int d_tab [6], r_tab [6], tw_tab [6], sa, ca;
        logic [17:0] rq [9];
        d_tab = '{2363, 0, 0, 2010, 1593, 1543};
        r_tab = '{0, -8620, -7287, 0, 0, 0};
        tw_tab = '{1, 0, 0, 1, -1, 0};
        rm = '{'{64'sd1073741824, 0, 0}, '{0, 64'sd1073741824, 0},
               '{0, 0, 64'sd1073741824}};
        p = '{0, 0, 0};
        for (int j = 0; j < 6; j++)
        begin
            cordic_sincos(q[j], c, s);
            sa = tw_tab[j];
            ca = (sa == 0) ? 1 : 0;
            lk[0][0] = c; lk[0][1] = -s * ca; lk[0][2] = s * sa;
            lk[1][0] = s; lk[1][1] = c * ca;  lk[1][2] = -c * sa;
            lk[2][0] = 0; lk[2][1] = 64'sd1073741824 * sa;
            lk[2][2] = 64'sd1073741824 * ca;
            lp[0] = round_shift(tenth_mm_q30(r_tab[j]) * c, 30);
            lp[1] = round_shift(tenth_mm_q30(r_tab[j]) * s, 30);
            lp[2] = tenth_mm_q30(d_tab[j]);
            for (int i = 0; i < 3; i++)
            begin
                for (int k = 0; k < 3; k++)
                    nr[i][k] = round_shift(rm[i][0] * lk[0][k] + rm[i][1] * lk[1][k]
                                           + rm[i][2] * lk[2][k], 30);
                acc = rm[i][0] * lp[0] + rm[i][1] * lp[1] + rm[i][2] * lp[2];
                np[i] = round_shift(acc, 30) + p[i];
            end
            rm = nr;
            p = np;
        end
        rlim = longint'(1) <<< FRAC;
        if (rlim > 131071)
            rlim = 131071;
        pose.px = 19'(clamp(round_shift(p[0], 30 - FRAC), -262144, 262143));
        pose.py = 19'(clamp(round_shift(p[1], 30 - FRAC), -262144, 262143));
        pose.pz = 19'(clamp(round_shift(p[2], 30 - FRAC), -262144, 262143));
        for (int i = 0; i < 9; i++)
            rq[i] = 18'(clamp(round_shift(rm[i / 3][i % 3], 30 - FRAC), -rlim, rlim));
        {pose.r00, pose.r01, pose.r02, pose.r10, pose.r11, pose.r12,
         pose.r20, pose.r21, pose.r22} = {rq[0], rq[1], rq[2], rq[3], rq[4], rq[5],
                                          rq[6], rq[7], rq[8]};
    endtask

    // Sends one request with burst-and-gap pacing and records its pose.
    task automatic send_angles(input logic signed [15:0] q [6]);
        pose_t pose;
        int gap;
        if (burst_left == 0)
        begin
            gap = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 12) : 0;
            if (gap > 0)
            begin
                in_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            burst_left = $urandom_range(1, 40);
        end
        burst_left--;
        in_valid <= 1'b1;
        for (int j = 0; j < 6; j++)
            ang[j] <= q[j];
        predict_pose(q, pose);
        expected_poses.push_back(pose);
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
    endtask

    task automatic test_directed();
        logic signed [15:0] q [6];
        logic signed [15:0] picks [8];
        picks = '{16'sh0000, 16'sh7fff, -16'sd32768, 16'sd16384, -16'sd16384,
                  16'sd16385, -16'sd16385, -16'sd1};
        for (int n = 0; n < 8; n++)
        begin
            for (int j = 0; j < 6; j++)
                q[j] = picks[n];
            send_angles(q);
        end
        for (int n = 0; n < 12; n++)
        begin
            for (int j = 0; j < 6; j++)
                q[j] = picks[(n + j) % 8];
            send_angles(q);
        end
    endtask

    task automatic test_random();
        logic signed [15:0] q [6];
        for (int n = 0; n < 1530; n++)
        begin
            for (int j = 0; j < 6; j++)
                q[j] = 16'($urandom);
            send_angles(q);
        end
        in_valid <= 1'b0;
    endtask

    // Receiver stall pattern: quiet stretches alternating with busy ones.
    initial
    begin
        out_stall = 1'b0;
        forever
        begin
            repeat ($urandom_range(20, 200)) @(posedge clk);
            repeat ($urandom_range(20, 200))
            begin
                @(posedge clk);
                out_stall <= ($urandom_range(0, 2) == 0);
            end
            @(posedge clk);
            out_stall <= 1'b0;
        end
    end

    // Compares each accepted result with the oldest expected pose.
    always @(posedge clk)
    begin
        pose_t got, want;
        if (rst_n && out_valid && !out_stall)
        begin
            got = '{pos_x, pos_y, pos_z, rot_00, rot_01, rot_02, rot_10, rot_11, rot_12,
                    rot_20, rot_21, rot_22};
            if (expected_poses.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result %h", got);
            end
            else
            begin
                want = expected_poses.pop_front();
                if (got !== want)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: expected %h actual %h", want, got);
                end
            end
        end
    end

    initial
    begin
        #3000000;
        $display("tb_top: FAIL");
        $finish;
    end

    initial
    begin
        mismatches = 0;
        burst_left = 0;
        rst_n = 1'b0;
        in_valid = 1'b0;
        for (int j = 0; j < 6; j++)
            ang[j] = '0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        test_random();
        while (expected_poses.size() != 0)
            @(posedge clk);
        repeat (LATENCY + 10) @(posedge clk);
        if (mismatches == 0 && expected_poses.size() == 0)
            $display("tb_top: PASS");
        else
            $display("tb_top: FAIL");
        $finish;
    end
endmodule
